[src/dpcq_pkg.sv]
// ---------------------------------------------------------------------------
// dpcq_pkg
// Shared types and constants of the deduplicating paced command queue:
// request and response payloads, status and request codes, sequencer states.
// ---------------------------------------------------------------------------
package dpcq_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_KEY_W = 32;

    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CMD_KEY_W-1:0] t_cmd_key;

    // configuration register reset values
    localparam t_cfg DEBOUNCE_RST      = 16'd1500;
    localparam t_cfg DELAY_BEFORE_RST  = 16'd300;
    localparam t_cfg DELAY_BETWEEN_RST = 16'd300;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 2'd0,
        CFG_DELAY_BEFORE  = 2'd1,
        CFG_DELAY_BETWEEN = 2'd2
    } t_cfg_idx;

    // request codes
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_POLL  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_type;

    // response status codes
    typedef enum logic [3:0] {
        ST_ENQUEUED  = 4'd0,
        ST_DUP       = 4'd1,
        ST_DEBOUNCED = 4'd2,
        ST_FULL      = 4'd3,
        ST_SENT      = 4'd4,
        ST_EMPTY     = 4'd5,
        ST_TOO_YOUNG = 4'd6,
        ST_GAP_SHORT = 4'd7,
        ST_CLEARED   = 4'd8
    } t_status;

    typedef struct packed {
        t_req_type req_type;
        t_cmd_key  cmd_key;
        t_time     now_ms;
    } t_req;

    typedef struct packed {
        t_status  status;
        logic     send_valid;
        t_cmd_key send_key;
    } t_rsp;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEBOUNCE,
        S_POLL,
        S_AGE,
        S_GAP,
        S_OUT
    } t_state;

endpackage

[src/dpcq_chan_if.sv]
// ---------------------------------------------------------------------------
// dpcq_chan_if
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
interface dpcq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/dpcq_ram.sv]
// ---------------------------------------------------------------------------
// dpcq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dpcq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/dpcq_tcmp.sv]
// ---------------------------------------------------------------------------
// dpcq_tcmp
// Shared elapsed-time compare: (now - stamp) mod 2^32 < limit.
// ---------------------------------------------------------------------------
module dpcq_tcmp (
    input  dpcq_pkg::t_time i_now,
    input  dpcq_pkg::t_time i_stamp,
    input  dpcq_pkg::t_cfg  i_limit,
    output logic            o_lt
);
    dpcq_pkg::t_time diff;

    // wrapping difference, then compare against zero-extended limit
    assign diff = i_now - i_stamp;
    assign o_lt = diff < dpcq_pkg::t_time'(i_limit);
endmodule

[src/dedup_paced_command_queue.sv]
// Sequence: add scans the stored keys from the head (one stored key read and
// compared per cycle), then checks debounce and full; poll checks empty, head
// age and gap; clear goes straight to the output register.
// Throughput: one request at a time; the next request is taken the cycle after
// the result is loaded into the output register, later while that is held.
// Reset: queue empty, last key forgotten, nothing sent, registers at defaults.
// ---------------------------------------------------------------------------
// dedup_paced_command_queue
// FIFO of command keys with duplicate suppression, debounce of the last sent
// key and paced sending, run by a small sequencer around one time compare.
// ---------------------------------------------------------------------------
module dedup_paced_command_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dpcq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  dpcq_pkg::t_cfg                 i_cfg_data,
    dpcq_chan_if.sink                      i_req,
    dpcq_chan_if.source                    o_rsp
);
    localparam int KeyW  = (KEY_BITS < dpcq_pkg::CMD_KEY_W) ? KEY_BITS : dpcq_pkg::CMD_KEY_W;
    localparam int PtrW  = $clog2(QUEUE_DEPTH);
    localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WordW = KeyW + dpcq_pkg::TIME_W;

    typedef logic [PtrW-1:0] t_ptr;
    typedef logic [CntW-1:0] t_cnt;
    typedef logic [KeyW-1:0] t_key;

    function automatic t_ptr f_next(input t_ptr p);
        return (p == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    // control registers
    dpcq_pkg::t_state r_state, n_state;
    t_ptr             r_head, r_tail;
    t_cnt             r_fill;
    t_key             r_last_key;
    logic             r_last_valid;
    dpcq_pkg::t_time  r_last_time;
    logic             r_ever_sent;
    logic             r_rd_pend;
    logic             r_rsp_valid;
    dpcq_pkg::t_cfg   r_debounce, r_before, r_between;

    // working registers
    t_key             r_key;
    dpcq_pkg::t_time  r_now;
    dpcq_pkg::t_status r_status, n_status;
    t_ptr             r_scan_ptr;
    t_cnt             r_scan_cnt;
    dpcq_pkg::t_rsp   r_rsp;

    // datapath signals
    logic             accept;
    logic             out_free;
    logic [WordW-1:0] rd_word;
    t_key             rd_key;
    dpcq_pkg::t_time  rd_time;
    t_ptr             raddr;
    logic             issue;
    logic             hit;
    logic             scan_done;
    logic             full;
    logic             lt;
    dpcq_pkg::t_time  cmp_stamp;
    dpcq_pkg::t_cfg   cmp_limit;
    logic             do_enq;
    logic             do_send;
    logic             do_clear;
    logic             load_key;

    assign i_req.ready = (r_state == dpcq_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_rsp_valid || o_rsp.ready;

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    assign rd_key    = rd_word[KeyW-1:0];
    assign rd_time   = rd_word[KeyW +: dpcq_pkg::TIME_W];
    assign hit       = r_rd_pend && (rd_key == r_key);
    assign scan_done = (r_scan_cnt == r_fill);
    assign full      = (r_fill == t_cnt'(QUEUE_DEPTH));

    // slot storage: stamp and key per entry
    dpcq_ram #(
        .WIDTH (WordW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (do_enq),
        .i_waddr (r_tail),
        .i_wdata ({r_now, r_key}),
        .i_raddr (raddr),
        .o_rdata (rd_word)
    );

    // shared elapsed-time compare
    dpcq_tcmp u_tcmp (
        .i_now   (r_now),
        .i_stamp (cmp_stamp),
        .i_limit (cmp_limit),
        .o_lt    (lt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dpcq_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_req.payload.req_type)
                        dpcq_pkg::REQ_ADD:   n_state = dpcq_pkg::S_SCAN;
                        dpcq_pkg::REQ_POLL:  n_state = dpcq_pkg::S_POLL;
                        dpcq_pkg::REQ_CLEAR: n_state = dpcq_pkg::S_OUT;
                        default:             n_state = dpcq_pkg::S_IDLE;
                    endcase
                end
            end
            dpcq_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = dpcq_pkg::S_OUT;
                end else if (scan_done && !r_rd_pend) begin
                    n_state = dpcq_pkg::S_DEBOUNCE;
                end
            end
            dpcq_pkg::S_DEBOUNCE: n_state = dpcq_pkg::S_OUT;
            dpcq_pkg::S_POLL: begin
                n_state = (r_fill == '0) ? dpcq_pkg::S_OUT : dpcq_pkg::S_AGE;
            end
            dpcq_pkg::S_AGE: begin
                n_state = lt ? dpcq_pkg::S_OUT : dpcq_pkg::S_GAP;
            end
            dpcq_pkg::S_GAP: n_state = dpcq_pkg::S_OUT;
            dpcq_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = dpcq_pkg::S_IDLE;
                end
            end
            default: n_state = dpcq_pkg::S_IDLE;
        endcase
    end

    // per-state actions and shared unit operand select
    always_comb begin
        n_status  = r_status;
        raddr     = r_scan_ptr;
        issue     = 1'b0;
        do_enq    = 1'b0;
        do_send   = 1'b0;
        do_clear  = 1'b0;
        load_key  = 1'b0;
        cmp_stamp = r_last_time;
        cmp_limit = r_between;
        unique case (r_state)
            dpcq_pkg::S_IDLE: begin
                if (accept && i_req.payload.req_type == dpcq_pkg::REQ_CLEAR) begin
                    do_clear = 1'b1;
                    n_status = dpcq_pkg::ST_CLEARED;
                end
            end
            dpcq_pkg::S_SCAN: begin
                issue = !scan_done && !hit;
                if (hit) begin
                    n_status = dpcq_pkg::ST_DUP;
                end
            end
            dpcq_pkg::S_DEBOUNCE: begin
                cmp_limit = r_debounce;
                if (r_last_valid && r_last_key == r_key && lt) begin
                    n_status = dpcq_pkg::ST_DEBOUNCED;
                end else if (full) begin
                    n_status = dpcq_pkg::ST_FULL;
                end else begin
                    do_enq   = 1'b1;
                    n_status = dpcq_pkg::ST_ENQUEUED;
                end
            end
            dpcq_pkg::S_POLL: begin
                raddr = r_head;
                if (r_fill == '0) begin
                    n_status = dpcq_pkg::ST_EMPTY;
                end
            end
            dpcq_pkg::S_AGE: begin
                cmp_stamp = rd_time;
                cmp_limit = r_before;
                if (lt) begin
                    n_status = dpcq_pkg::ST_TOO_YOUNG;
                end else begin
                    load_key = 1'b1;
                end
            end
            dpcq_pkg::S_GAP: begin
                if (r_ever_sent && lt) begin
                    n_status = dpcq_pkg::ST_GAP_SHORT;
                end else begin
                    do_send  = 1'b1;
                    n_status = dpcq_pkg::ST_SENT;
                end
            end
            dpcq_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dpcq_pkg::S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_last_key   <= '0;
            r_last_valid <= 1'b0;
            r_last_time  <= '0;
            r_ever_sent  <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_rsp_valid  <= 1'b0;
            r_debounce   <= dpcq_pkg::DEBOUNCE_RST;
            r_before     <= dpcq_pkg::DELAY_BEFORE_RST;
            r_between    <= dpcq_pkg::DELAY_BETWEEN_RST;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= issue;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dpcq_pkg::CFG_DEBOUNCE:      r_debounce <= i_cfg_data;
                    dpcq_pkg::CFG_DELAY_BEFORE:  r_before   <= i_cfg_data;
                    dpcq_pkg::CFG_DELAY_BETWEEN: r_between  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // queue pointers and last-sent bookkeeping
            if (do_clear) begin
                r_head       <= '0;
                r_tail       <= '0;
                r_fill       <= '0;
                r_last_key   <= '0;
                r_last_valid <= 1'b0;
            end else if (do_enq) begin
                r_tail <= f_next(r_tail);
                r_fill <= r_fill + t_cnt'(1);
            end else if (do_send) begin
                r_head       <= f_next(r_head);
                r_fill       <= r_fill - t_cnt'(1);
                r_last_key   <= r_key;
                r_last_valid <= 1'b1;
                r_last_time  <= r_now;
                r_ever_sent  <= 1'b1;
            end

            // output register: drained by a transfer, loaded when free
            if (r_state == dpcq_pkg::S_OUT && out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (accept) begin
            r_key      <= t_key'(i_req.payload.cmd_key);
            r_now      <= i_req.payload.now_ms;
            r_scan_ptr <= r_head;
            r_scan_cnt <= '0;
        end else if (load_key) begin
            r_key <= rd_key;
        end else if (issue) begin
            r_scan_ptr <= f_next(r_scan_ptr);
            r_scan_cnt <= r_scan_cnt + t_cnt'(1);
        end
        if (r_state == dpcq_pkg::S_OUT && out_free) begin
            r_rsp.status     <= r_status;
            r_rsp.send_valid <= (r_status == dpcq_pkg::ST_SENT);
            r_rsp.send_key   <= (r_status == dpcq_pkg::ST_SENT)
                                ? dpcq_pkg::t_cmd_key'(r_key) : '0;
        end
    end
endmodule

[verif/tb_dedup_paced_command_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dedup_paced_command_queue
// Drives add, poll and clear requests with moving timestamps into the
// command queue under random stalls on both channels. A scoreboard class
// tracks queue contents, debounce and pacing, and checks every response.
// ---------------------------------------------------------------------------
module tb_dedup_paced_command_queue;

    localparam int          DEPTH       = 16;
    localparam int          SETTLE      = 32;
    localparam int          PHASE_ITEMS = 90;
    localparam int          PHASES      = 5;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;

    // queue model plus response checker
    class cmd_queue_scoreboard;
        dpcq_pkg::t_cmd_key slot_key[DEPTH];
        dpcq_pkg::t_time    slot_time[DEPTH];
        int                 head;
        int                 tail;
        int                 count;
        dpcq_pkg::t_cmd_key last_sent;
        bit                 last_ok;
        dpcq_pkg::t_time    sent_at;
        bit                 any_sent;
        dpcq_pkg::t_cfg     debounce;
        dpcq_pkg::t_cfg     hold_min;
        dpcq_pkg::t_cfg     gap_min;
        dpcq_pkg::t_rsp     expected_rsps[$];
        int                 errors;
        int                 checked;
        int                 status_seen[dpcq_pkg::ST_CLEARED+1];

        function new();
            head      = 0;
            tail      = 0;
            count     = 0;
            last_sent = '0;
            last_ok   = 0;
            sent_at   = '0;
            any_sent  = 0;
            debounce  = dpcq_pkg::DEBOUNCE_RST;
            hold_min  = dpcq_pkg::DELAY_BEFORE_RST;
            gap_min   = dpcq_pkg::DELAY_BETWEEN_RST;
            errors    = 0;
            checked   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_reg(dpcq_pkg::t_cfg_idx idx, dpcq_pkg::t_cfg value);
            case (idx)
                dpcq_pkg::CFG_DEBOUNCE:      debounce = value;
                dpcq_pkg::CFG_DELAY_BEFORE:  hold_min = value;
                dpcq_pkg::CFG_DELAY_BETWEEN: gap_min  = value;
                default: ;
            endcase
        endfunction

        // duplicate search, then debounce, then full check
        function dpcq_pkg::t_status add_key(dpcq_pkg::t_cmd_key key, dpcq_pkg::t_time now);
            int              p;
            dpcq_pkg::t_time since;
            p = head;
            for (int i = 0; i < count; i++) begin
                if (slot_key[p] == key) return dpcq_pkg::ST_DUP;
                p = (p + 1) % DEPTH;
            end
            since = now - sent_at;
            if (last_ok && last_sent == key && since < debounce) return dpcq_pkg::ST_DEBOUNCED;
            if (count >= DEPTH) return dpcq_pkg::ST_FULL;
            slot_key[tail]  = key;
            slot_time[tail] = now;
            tail = (tail + 1) % DEPTH;
            count++;
            return dpcq_pkg::ST_ENQUEUED;
        endfunction

        // head must be old enough, and the gap since the last send long enough
        function dpcq_pkg::t_status poll_head(dpcq_pkg::t_time now,
                                              output dpcq_pkg::t_cmd_key key);
            dpcq_pkg::t_time age;
            dpcq_pkg::t_time gap;
            key = '0;
            if (count == 0) return dpcq_pkg::ST_EMPTY;
            age = now - slot_time[head];
            if (age < hold_min) return dpcq_pkg::ST_TOO_YOUNG;
            gap = now - sent_at;
            if (any_sent && gap < gap_min) return dpcq_pkg::ST_GAP_SHORT;
            key       = slot_key[head];
            last_sent = key;
            last_ok   = 1;
            sent_at   = now;
            any_sent  = 1;
            head      = (head + 1) % DEPTH;
            count--;
            return dpcq_pkg::ST_SENT;
        endfunction

        function void note_request(dpcq_pkg::t_req r);
            dpcq_pkg::t_rsp     want;
            dpcq_pkg::t_cmd_key key;
            want = '0;
            key  = '0;
            case (r.req_type)
                dpcq_pkg::REQ_ADD:   want.status = add_key(r.cmd_key, r.now_ms);
                dpcq_pkg::REQ_POLL:  want.status = poll_head(r.now_ms, key);
                dpcq_pkg::REQ_CLEAR: begin
                    // pacing history survives a clear
                    head        = 0;
                    tail        = 0;
                    count       = 0;
                    last_sent   = '0;
                    last_ok     = 0;
                    want.status = dpcq_pkg::ST_CLEARED;
                end
                default: return;
            endcase
            want.send_valid = (want.status == dpcq_pkg::ST_SENT);
            want.send_key   = want.send_valid ? key : '0;
            expected_rsps.insert(expected_rsps.size(), want);
        endfunction

        function void check_response(dpcq_pkg::t_rsp got);
            dpcq_pkg::t_rsp want;
            if (expected_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual status %0d key %h",
                         $time, got.status, got.send_key);
                return;
            end
            want = expected_rsps[0];
            expected_rsps.delete(0);
            checked++;
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
            end
            if (got.send_valid !== want.send_valid) begin
                errors++;
                $display("%0t: send_valid mismatch, expected %b, actual %b",
                         $time, want.send_valid, got.send_valid);
            end
            if (got.send_key !== want.send_key) begin
                errors++;
                $display("%0t: send_key mismatch, expected %h, actual %h",
                         $time, want.send_key, got.send_key);
            end
            status_seen[want.status]++;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we;
    dpcq_pkg::t_cfg_idx i_cfg_idx;
    dpcq_pkg::t_cfg     i_cfg_data;

    dpcq_chan_if #(.T(dpcq_pkg::t_req)) req_if ();
    dpcq_chan_if #(.T(dpcq_pkg::t_rsp)) rsp_if ();

    dedup_paced_command_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    cmd_queue_scoreboard sb = new();

    dpcq_pkg::t_time    now_q;
    dpcq_pkg::t_cmd_key key_pool[6];
    bit                 no_idle;
    int                 rdy_hold = 0;
    int                 items_accepted;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // time moves forward by small or large steps, sometimes jumps anywhere
    function automatic dpcq_pkg::t_time advance_time(int unsigned scale);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return now_q + $urandom_range(0, scale);
        if (r < 95) return now_q + $urandom_range(0, scale * 4);
        return $urandom;
    endfunction

    // response side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rdy_hold > 0) begin
            rdy_hold--;
        end else if (no_idle || $urandom_range(0, 99) < 60) begin
            rsp_if.ready <= 1'b1;
            rdy_hold = $urandom_range(0, 7);
        end else begin
            rsp_if.ready <= 1'b0;
            rdy_hold = pick_gap() - 1;
        end
    end

    // response transfer monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
    end

    task automatic send_request(dpcq_pkg::t_req r);
        req_if.payload <= r;
        req_if.valid   <= 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(r);
        items_accepted++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for all results, then for any request that gives no result
    task automatic drain_queue();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(dpcq_pkg::t_cfg_idx idx, dpcq_pkg::t_cfg value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_config(dpcq_pkg::t_cfg deb, dpcq_pkg::t_cfg hold,
                                dpcq_pkg::t_cfg gap);
        write_reg(dpcq_pkg::CFG_DEBOUNCE, deb);
        write_reg(dpcq_pkg::CFG_DELAY_BEFORE, hold);
        write_reg(dpcq_pkg::CFG_DELAY_BETWEEN, gap);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_fields(logic [1:0] kind, dpcq_pkg::t_cmd_key key,
                               dpcq_pkg::t_time now);
        dpcq_pkg::t_req r;
        r.req_type = dpcq_pkg::t_req_type'(kind);
        r.cmd_key  = key;
        r.now_ms   = now;
        send_request(r);
    endtask

    // walk through every status at least once, filling the queue to the top on the way
    task automatic run_directed();
        send_fields(dpcq_pkg::REQ_POLL, 32'h0, 32'd0);
        send_fields(dpcq_pkg::REQ_ADD, 32'h0000_0000, 32'd0);
        send_fields(dpcq_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'd10);
        send_fields(dpcq_pkg::REQ_POLL, 32'h0, 32'd100);
        send_fields(dpcq_pkg::REQ_POLL, 32'h0, 32'd300);
        send_fields(dpcq_pkg::REQ_ADD, 32'h0000_0000, 32'd400);
        send_fields(dpcq_pkg::REQ_POLL, 32'h0, 32'd400);
        send_fields(dpcq_pkg::REQ_POLL, 32'h0, 32'd600);
        send_fields(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(dpcq_pkg::REQ_CLEAR, 32'h0, 32'd650);
        send_fields(dpcq_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'd700);
        for (int i = 1; i < DEPTH; i++) begin
            send_fields(dpcq_pkg::REQ_ADD, 32'h1 << (i * 2), 32'd700);
        end
        send_fields(dpcq_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'd710);
        send_fields(dpcq_pkg::REQ_ADD, 32'h5A5A_5A5A, 32'd720);
        now_q = 32'd720;
    endtask

    // one random phase: key reuse from a small pool keeps duplicates common
    task automatic run_phase(int unsigned scale, int add_pct, int pool_pct);
        dpcq_pkg::t_req r;
        int             counted;
        int unsigned    roll;
        counted = 0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        while (counted < PHASE_ITEMS) begin
            roll  = $urandom_range(0, 99);
            now_q = advance_time(scale);
            r.cmd_key = ($urandom_range(0, 99) < pool_pct) ?
                        key_pool[$urandom_range(0, 5)] : dpcq_pkg::t_cmd_key'($urandom);
            r.now_ms  = now_q;
            if (roll < add_pct)   r.req_type = dpcq_pkg::REQ_ADD;
            else if (roll < 94)   r.req_type = dpcq_pkg::REQ_POLL;
            else if (roll < 98)   r.req_type = dpcq_pkg::REQ_CLEAR;
            else                  r.req_type = dpcq_pkg::t_req_type'(REQ_UNUSED);
            if (r.req_type != dpcq_pkg::t_req_type'(REQ_UNUSED)) counted++;
            send_request(r);
            // halfway, hold the sender until the block has answered everything; else pause it now and then
            if (counted == PHASE_ITEMS / 2) drain_queue();
            else if (counted < PHASE_ITEMS)
                pause_sender((no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap());
        end
        drain_queue();
    endtask

    initial begin
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= dpcq_pkg::CFG_DEBOUNCE;
        i_cfg_data     <= '0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        no_idle        = 0;
        items_accepted = 0;
        now_q          = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_queue();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_config(dpcq_pkg::DEBOUNCE_RST, dpcq_pkg::DELAY_BEFORE_RST,
                                 dpcq_pkg::DELAY_BETWEEN_RST);
                    run_phase(400, 50, 75);
                end
                1: begin
                    no_idle = 1;
                    write_config('0, '0, '0);
                    run_phase(20, 50, 75);
                    no_idle = 0;
                end
                2: begin
                    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    now_q = 32'hFFFF_0000;
                    run_phase(40000, 45, 75);
                end
                3: begin
                    write_config(dpcq_pkg::t_cfg'($urandom_range(0, 800)),
                                 dpcq_pkg::t_cfg'($urandom_range(0, 800)),
                                 dpcq_pkg::t_cfg'($urandom_range(0, 800)));
                    run_phase(150, 75, 20);
                end
                default: begin
                    write_config(dpcq_pkg::t_cfg'($urandom_range(0, 65535)),
                                 dpcq_pkg::t_cfg'($urandom_range(0, 65535)),
                                 dpcq_pkg::t_cfg'($urandom_range(0, 65535)));
                    run_phase(30000, 50, 60);
                end
            endcase
        end

        $display("Run covered %0d requests over %0d register settings, %0d responses checked",
                 items_accepted, PHASES, sb.checked);
        $display("Outcomes: %0d sent, %0d dup, %0d debounced, %0d full, %0d too young, %0d gap",
                 sb.status_seen[dpcq_pkg::ST_SENT], sb.status_seen[dpcq_pkg::ST_DUP],
                 sb.status_seen[dpcq_pkg::ST_DEBOUNCED], sb.status_seen[dpcq_pkg::ST_FULL],
                 sb.status_seen[dpcq_pkg::ST_TOO_YOUNG],
                 sb.status_seen[dpcq_pkg::ST_GAP_SHORT]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run time guard
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
